[rtl/core/shs_pkg.sv]
package shs_pkg;

  localparam int BLOCK_BITS = 512;
  localparam int WORD_BITS  = 32;
  localparam int BLK_WORDS  = BLOCK_BITS / WORD_BITS;
  localparam int HASH_WORDS = 8;
  localparam int ROUNDS     = 64;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int         LEN_POS  = 56;
  localparam logic [5:0] PAD_STOP = 6'(LEN_POS - 1);
  localparam logic [5:0] BLK_LAST = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } shs_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } shs_out_t;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] block;
    logic                  last;
  } blk_job_t;

  localparam logic [31:0] H_INIT [HASH_WORDS] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

[rtl/core/sha256_stream_hasher.sv]
// A block that reaches the compression unit is loaded, run through 64 rounds
// (one per cycle) and then folded into the hash; the end transaction adds
// byte-serial padding and length insertion.
// Throughput: one byte per cycle outside padding, while the two-entry block
// queue has room; sustained rate is set by the compression unit.
// Reset: synchronous active-low rst_n loads the initial hash, empties the queue.
module sha256_stream_hasher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  shs_pkg::shs_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output shs_pkg::shs_out_t  out_data
);
  import shs_pkg::*;

  logic     push, q_full, q_pop, q_empty;
  blk_job_t push_job, pop_job;

  shs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push_o   (push),
    .job_o    (push_job),
    .q_full_i (q_full)
  );

  shs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (pop_job),
    .empty_o (q_empty)
  );

  shs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job_i   (pop_job),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/shs_front.sv]
module shs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  shs_pkg::shs_in_t   in_data,
  output logic               push_o,
  output shs_pkg::blk_job_t  job_o,
  input  logic               q_full_i
);
  import shs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_LEN  = 2'd2;

  logic [1:0]            st_r, st_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic [63:0]           len_r, len_nxt;
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic                  pend_r, pend_nxt;
  logic                  plast_r, plast_nxt;
  logic                  first_r, first_nxt;
  logic                  stall;
  logic                  shift_en;
  logic [7:0]            sbyte;

  assign stall    = pend_r && q_full_i;
  assign push_o   = pend_r && !q_full_i;
  assign job_o    = '{block: blk_r, last: plast_r};
  assign in_ready = (st_r == S_IDLE) && !stall;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    blk_nxt   = blk_r;
    pend_nxt  = pend_r;
    plast_nxt = plast_r;
    first_nxt = first_r;
    shift_en  = 1'b0;
    sbyte     = '0;
    if (push_o) begin
      pend_nxt = 1'b0;
    end
    if (!stall) begin
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.byte_present) begin
              shift_en = 1'b1;
              sbyte    = in_data.data_byte;
              len_nxt  = len_r + 64'd8;
            end
            if (in_data.message_end) begin
              st_nxt    = S_PAD;
              first_nxt = 1'b1;
            end
          end
        end
        S_PAD: begin
          shift_en  = 1'b1;
          sbyte     = first_r ? PAD_BYTE : 8'h00;
          first_nxt = 1'b0;
          if (cnt_r == PAD_STOP) begin
            st_nxt = S_LEN;
          end
        end
        S_LEN: begin
          shift_en = 1'b1;
          sbyte    = len_r[63:56];
          len_nxt  = {len_r[55:0], 8'h00};
          if (cnt_r == BLK_LAST) begin
            st_nxt = S_IDLE;
          end
        end
        default: begin
          st_nxt = S_IDLE;
        end
      endcase
    end
    if (shift_en) begin
      blk_nxt = {blk_r[BLOCK_BITS-9:0], sbyte};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == BLK_LAST) begin
        pend_nxt  = 1'b1;
        plast_nxt = (st_r == S_LEN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= '0;
      len_r   <= '0;
      pend_r  <= 1'b0;
      plast_r <= 1'b0;
      first_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
      plast_r <= plast_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(cnt_r) && $stable(st_r))
    else $error("front advanced while queue full");

  a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LEN) && !stall && (cnt_r == BLK_LAST) |=> pend_r && plast_r && (len_r == '0))
    else $error("final block not queued");

endmodule

[rtl/core/shs_fifo.sv]
module shs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  shs_pkg::blk_job_t  job_i,
  output logic               full_o,
  input  logic               pop_i,
  output shs_pkg::blk_job_t  job_o,
  output logic               empty_o
);
  import shs_pkg::*;

  blk_job_t       ent_r [QDEPTH];
  logic [QPW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;
  logic           do_push, do_pop;

  assign full_o  = (cnt_r == QCW'(QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign job_o   = ent_r[rp_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + QPW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + QPW'(1);
      end
      cnt_r <= cnt_r + QCW'(do_push) - QCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= job_i;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("queue count out of range");

endmodule

[rtl/core/shs_core.sv]
module shs_core (
  input  logic               clk,
  input  logic               rst_n,
  input  shs_pkg::blk_job_t  q_job_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               out_valid,
  input  logic               out_ready,
  output shs_pkg::shs_out_t  out_data
);
  import shs_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_FIN  = 2'd2;

  logic [1:0]  st_r;
  logic [5:0]  rnd_r;
  logic        last_r;
  logic        emit_r;
  logic [2:0]  idx_r;
  logic [31:0] hw_r  [HASH_WORDS];
  logic [31:0] wk_r  [HASH_WORDS];
  logic [31:0] w_r   [BLK_WORDS];
  logic [31:0] dig_r [HASH_WORDS];
  logic [31:0] wk_nxt [HASH_WORDS];
  logic [31:0] sum    [HASH_WORDS];
  logic [31:0] t1, t2, w_new;
  logic        out_fire;
  logic        fold;

  assign q_pop_o   = (st_r == B_IDLE) && !q_empty_i;
  assign out_valid = emit_r;
  assign out_fire  = emit_r && out_ready;
  assign out_data  = '{digest_word: dig_r[0], word_index: idx_r,
                       final_word: (idx_r == 3'd7)};
  assign fold      = (st_r == B_FIN) && (!last_r || !emit_r);

  always_comb begin
    t1 = wk_r[7] + bsig1(wk_r[4]) + (wk_r[6] ^ (wk_r[4] & (wk_r[5] ^ wk_r[6])))
       + ROUND_K[rnd_r] + w_r[0];
    t2 = bsig0(wk_r[0]) + (((wk_r[0] | wk_r[1]) & wk_r[2]) | (wk_r[0] & wk_r[1]));
    wk_nxt[0] = t1 + t2;
    wk_nxt[1] = wk_r[0];
    wk_nxt[2] = wk_r[1];
    wk_nxt[3] = wk_r[2];
    wk_nxt[4] = wk_r[3] + t1;
    wk_nxt[5] = wk_r[4];
    wk_nxt[6] = wk_r[5];
    wk_nxt[7] = wk_r[6];
    w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
    for (int i = 0; i < HASH_WORDS; i++) begin
      sum[i] = hw_r[i] + wk_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      rnd_r  <= '0;
      last_r <= 1'b0;
      emit_r <= 1'b0;
      idx_r  <= '0;
      for (int i = 0; i < HASH_WORDS; i++) begin
        hw_r[i] <= H_INIT[i];
      end
    end else begin
      case (st_r)
        B_IDLE: begin
          if (q_pop_o) begin
            last_r <= q_job_i.last;
            rnd_r  <= '0;
            st_r   <= B_RUN;
          end
        end
        B_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'(ROUNDS - 1)) begin
            st_r <= B_FIN;
          end
        end
        B_FIN: begin
          if (fold) begin
            st_r <= B_IDLE;
            for (int i = 0; i < HASH_WORDS; i++) begin
              hw_r[i] <= last_r ? H_INIT[i] : sum[i];
            end
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
      if (fold && last_r) begin
        emit_r <= 1'b1;
        idx_r  <= '0;
      end else if (out_fire) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          emit_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == B_IDLE) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        wk_r[i] <= hw_r[i];
      end
      for (int i = 0; i < BLK_WORDS; i++) begin
        w_r[i] <= q_job_i.block[BLOCK_BITS-1-WORD_BITS*i -: WORD_BITS];
      end
    end else if (st_r == B_RUN) begin
      wk_r <= wk_nxt;
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BLK_WORDS-1] <= w_new;
    end
    if (fold && last_r) begin
      dig_r <= sum;
    end else if (out_fire) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_RUN) && (rnd_r == 6'(ROUNDS - 1)) |=> (st_r == B_FIN))
    else $error("round count overrun");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && (idx_r == 3'd7) |=> !emit_r)
    else $error("digest emission did not stop after last word");

endmodule
